@@ rtl/core/ctt_pkg.sv @@
package ctt_pkg;

  // Table geometry
  localparam int ENTRIES = 64;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int OUT_CNT_W = 7;

  // Operation codes
  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_FIND   = 2'd1;
  localparam logic [1:0] KIND_FINISH = 2'd2;
  localparam logic [1:0] KIND_READ   = 2'd3;

  // Status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_MISSING = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] conn_key;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] src_port;
    logic [15:0] dst_port;
  } req_t;

  typedef struct packed {
    logic [1:0]           status;
    logic [15:0]          found_key;
    logic [31:0]          rec_src_addr;
    logic [31:0]          rec_dst_addr;
    logic [15:0]          rec_src_port;
    logic [15:0]          rec_dst_port;
    logic                 rec_finished;
    logic [OUT_CNT_W-1:0] entry_count;
  } rsp_t;

  // One stored connection record
  typedef struct packed {
    logic [15:0] key;
    logic [31:0] src;
    logic [31:0] dst;
    logic [15:0] sport;
    logic [15:0] dport;
    logic        done;
  } rec_t;

  // Record memory access for one cycle
  typedef struct packed {
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    rec_t             wr_data;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
  } ram_cmd_t;

endpackage

@@ rtl/core/ctt_store.sv @@
module ctt_store (
  input  logic              clk,
  input  ctt_pkg::ram_cmd_t cmd,
  output ctt_pkg::rec_t     rd_data
);
  import ctt_pkg::*;

  rec_t mem [ENTRIES];

  // Write one record, read one record; the read data is registered
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[cmd.wr_addr] <= cmd.wr_data;
    end
    if (cmd.rd_en) begin
      rd_data <= mem[cmd.rd_addr];
    end
  end

endmodule

@@ rtl/core/connection_tuple_table_core.sv @@
// Channel | Handshake           | Payload        | Direction
// request | req_valid/req_stall | req (req_t)    | into the table
// result  | rsp_valid/rsp_stall | rsp (rsp_t)    | out of the table
//
// Insert moves straight to the done state on acceptance; find, finish
// and read walk the stored records one per cycle through the single memory
// read port, then move to the done state, which loads the result register.
// Reset empties the table at once; no clearing pass runs.
// A result waiting under rsp_stall holds the next result back; the request
// side stalls while an operation is in progress.
module connection_tuple_table_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  ctt_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output ctt_pkg::rsp_t rsp
);
  import ctt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t           state;
  req_t             op;
  rsp_t             res;
  rsp_t             res_init;
  rsp_t             res_hit;
  rsp_t             rsp_load;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] scan_idx;
  logic [CNT_W-1:0] rd_idx;
  logic             rd_pend;

  ram_cmd_t cmd;
  rec_t     rd_data;

  logic accept;
  logic has_room;
  logic tuple_hit;
  logic key_hit;
  logic hit;
  logic last;
  logic out_free;

  ctt_store u_store (
    .clk     (clk),
    .cmd     (cmd),
    .rd_data (rd_data)
  );

  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;
  assign has_room  = (count < CNT_W'(ENTRIES));
  assign out_free  = !rsp_valid || !rsp_stall;

  // Compare the record just read against the held request
  assign tuple_hit = !rd_data.done && (rd_data.src == op.src_addr) &&
                     (rd_data.dst == op.dst_addr) && (rd_data.sport == op.src_port) &&
                     (rd_data.dport == op.dst_port);
  assign key_hit   = (rd_data.key == op.conn_key);
  assign hit       = (op.kind == KIND_FIND) ? tuple_hit : key_hit;
  assign last      = ((rd_idx + CNT_W'(1)) == count);

  // Seed the result of a newly accepted transaction
  always_comb begin
    res_init = '0;
    if (req.kind == KIND_INSERT) begin
      res_init.status = has_room ? ST_OK : ST_FULL;
    end else if (count == '0) begin
      res_init.status = ST_MISSING;
    end
  end

  // Fill the result from the matching record
  always_comb begin
    res_hit           = res;
    res_hit.status    = ST_OK;
    res_hit.found_key = rd_data.key;
    if (op.kind == KIND_READ) begin
      res_hit.rec_src_addr = rd_data.src;
      res_hit.rec_dst_addr = rd_data.dst;
      res_hit.rec_src_port = rd_data.sport;
      res_hit.rec_dst_port = rd_data.dport;
      res_hit.rec_finished = rd_data.done;
    end
  end

  // Stamp the entry count onto the outgoing result
  always_comb begin
    rsp_load             = res;
    rsp_load.entry_count = OUT_CNT_W'(count);
  end

  // Drive memory: read during a scan, append on insert, write back the finished mark on a finish key hit
  always_comb begin
    cmd         = '0;
    cmd.rd_en   = (state == S_SCAN) && (scan_idx < count);
    cmd.rd_addr = scan_idx[IDX_W-1:0];
    if (accept && (req.kind == KIND_INSERT) && has_room) begin
      cmd.wr_en         = 1'b1;
      cmd.wr_addr       = count[IDX_W-1:0];
      cmd.wr_data.key   = req.conn_key;
      cmd.wr_data.src   = req.src_addr;
      cmd.wr_data.dst   = req.dst_addr;
      cmd.wr_data.sport = req.src_port;
      cmd.wr_data.dport = req.dst_port;
      cmd.wr_data.done  = 1'b0;
    end else if ((state == S_SCAN) && rd_pend && hit && (op.kind == KIND_FINISH)) begin
      cmd.wr_en        = 1'b1;
      cmd.wr_addr      = rd_idx[IDX_W-1:0];
      cmd.wr_data      = rd_data;
      cmd.wr_data.done = 1'b1;
    end
  end

  // Sequence one operation at a time
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rd_pend   <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if ((state == S_DONE) && out_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            op       <= req;
            res      <= res_init;
            scan_idx <= '0;
            rd_pend  <= 1'b0;
            if (req.kind == KIND_INSERT) begin
              if (has_room) begin
                count <= count + CNT_W'(1);
              end
              state <= S_DONE;
            end else if (count == '0) begin
              state <= S_DONE;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          // Advance the read pointer, check the record returned last cycle
          rd_pend <= cmd.rd_en;
          rd_idx  <= scan_idx;
          if (cmd.rd_en) begin
            scan_idx <= scan_idx + CNT_W'(1);
          end
          if (rd_pend) begin
            if (hit) begin
              res   <= res_hit;
              state <= S_DONE;
            end else if (last) begin
              res.status <= ST_MISSING;
              state      <= S_DONE;
            end
          end
        end
        S_DONE: begin
          // Hand the result over once the output register is free
          if (out_free) begin
            rsp   <= rsp_load;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ rtl/core/ctt_chk.sv @@
module ctt_chk (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_stall,
  input ctt_pkg::req_t req,
  input logic          rsp_valid,
  input logic          rsp_stall,
  input ctt_pkg::rsp_t rsp
);
  import ctt_pkg::*;

  // Hold a stalled result transaction
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled result changed");

  // Keep the count within the table size
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (int'(rsp.entry_count) <= ENTRIES))
    else $error("entry count beyond table size");

  // Report full only with a full table
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status == ST_FULL) |-> (rsp.entry_count == OUT_CNT_W'(ENTRIES)))
    else $error("full status with free entries");

  // Zero all record fields on a failed transaction
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status != ST_OK) |->
      (rsp.found_key == '0) && (rsp.rec_src_addr == '0) && (rsp.rec_dst_addr == '0) &&
      (rsp.rec_src_port == '0) && (rsp.rec_dst_port == '0) && !rsp.rec_finished)
    else $error("failed transaction carries record data");

endmodule

bind connection_tuple_table_core ctt_chk u_ctt_chk (.*);

@@ tb/connection_table_checker.sv @@
`timescale 1ns / 100ps
module connection_table_checker
  import ctt_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  input  logic req_stall,
  input  req_t req,
  input  logic rsp_valid,
  input  logic rsp_stall,
  input  rsp_t rsp,
  output int   errors,
  output int   pending
);

  // Shadow copy of the connection table
  rec_t conn_rec [ENTRIES];
  int   conn_total;

  // Results owed by the table, oldest first
  rsp_t awaited_rsp [$];
  rsp_t want;
  int   rsp_seen;

  // Apply one operation to the shadow table and return its result
  function automatic rsp_t apply_table_op(req_t r);
    rsp_t res;
    int   hit;
    res = '0;
    hit = -1;
    case (r.kind)
      KIND_INSERT: begin
        if (conn_total >= ENTRIES) begin
          res.status = ST_FULL;
        end else begin
          conn_rec[conn_total].key   = r.conn_key;
          conn_rec[conn_total].src   = r.src_addr;
          conn_rec[conn_total].dst   = r.dst_addr;
          conn_rec[conn_total].sport = r.src_port;
          conn_rec[conn_total].dport = r.dst_port;
          conn_rec[conn_total].done  = 1'b0;
          conn_total++;
          res.status = ST_OK;
        end
      end
      KIND_FIND: begin
        // earliest open record with a matching tuple
        for (int i = 0; i < conn_total; i++) begin
          if (hit < 0 && !conn_rec[i].done && conn_rec[i].src == r.src_addr &&
              conn_rec[i].dst == r.dst_addr && conn_rec[i].sport == r.src_port &&
              conn_rec[i].dport == r.dst_port) begin
            hit = i;
          end
        end
        if (hit < 0) begin
          res.status = ST_MISSING;
        end else begin
          res.status    = ST_OK;
          res.found_key = conn_rec[hit].key;
        end
      end
      default: begin
        // finish and read both act on the earliest record with the key
        for (int i = 0; i < conn_total; i++) begin
          if (hit < 0 && conn_rec[i].key == r.conn_key) hit = i;
        end
        if (hit < 0) begin
          res.status = ST_MISSING;
        end else if (r.kind == KIND_FINISH) begin
          conn_rec[hit].done = 1'b1;
          res.status    = ST_OK;
          res.found_key = conn_rec[hit].key;
        end else begin
          res.status       = ST_OK;
          res.found_key    = conn_rec[hit].key;
          res.rec_src_addr = conn_rec[hit].src;
          res.rec_dst_addr = conn_rec[hit].dst;
          res.rec_src_port = conn_rec[hit].sport;
          res.rec_dst_port = conn_rec[hit].dport;
          res.rec_finished = conn_rec[hit].done;
        end
      end
    endcase
    res.entry_count = conn_total[OUT_CNT_W-1:0];
    return res;
  endfunction

  // Count a field mismatch, report only the first few
  task automatic flag_field(input string name, input logic [31:0] exp_val,
                            input logic [31:0] got_val);
    if (got_val !== exp_val) begin
      if (errors < 10) begin
        $display("result %0d: %s expected %0h, got %0h", rsp_seen, name, exp_val, got_val);
      end
      errors++;
    end
  endtask

  // Record each request transaction, check each result transaction
  always @(posedge clk) begin
    if (rst) begin
      conn_total = 0;
      awaited_rsp.delete();
      errors   = 0;
      rsp_seen = 0;
      pending <= 0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (awaited_rsp.size() == 0) begin
          if (errors < 10) begin
            $display("result %0d: no result was owed, got %0h", rsp_seen, rsp);
          end
          errors++;
        end else begin
          want = awaited_rsp.pop_front();
          flag_field("status", 32'(want.status), 32'(rsp.status));
          flag_field("found_key", 32'(want.found_key), 32'(rsp.found_key));
          flag_field("rec_src_addr", want.rec_src_addr, rsp.rec_src_addr);
          flag_field("rec_dst_addr", want.rec_dst_addr, rsp.rec_dst_addr);
          flag_field("rec_src_port", 32'(want.rec_src_port), 32'(rsp.rec_src_port));
          flag_field("rec_dst_port", 32'(want.rec_dst_port), 32'(rsp.rec_dst_port));
          flag_field("rec_finished", 32'(want.rec_finished), 32'(rsp.rec_finished));
          flag_field("entry_count", 32'(want.entry_count), 32'(rsp.entry_count));
        end
        rsp_seen++;
      end
      if (req_valid && !req_stall) begin
        awaited_rsp.push_back(apply_table_op(req));
      end
      pending <= awaited_rsp.size();
    end
  end

endmodule

@@ tb/connection_tuple_table_core_tb.sv @@
`timescale 1ns / 100ps
module connection_tuple_table_core_tb;
  import ctt_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_CYCLES = 500;
  localparam int HOLD_AFTER  = 300;
  localparam int TAIL_CYCLES = 100;
  localparam int RANDOM_OPS  = 1630;
  localparam int DRAIN_AT    = 1100;
  localparam int KEY_POOL    = 47;

  // Directed tuple used for duplicate checks
  localparam logic [31:0] TUP_SRC   = 32'h0A00_0001;
  localparam logic [31:0] TUP_DST   = 32'hC0A8_0001;
  localparam logic [15:0] TUP_SPORT = 16'h1234;
  localparam logic [15:0] TUP_DPORT = 16'h0050;

  typedef enum int {PACE_FREE, PACE_LIGHT, PACE_HEAVY, PACE_PERIODIC} pace_t;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req       = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;
  logic hold_rsp  = 1'b0;

  int    check_errors;
  int    check_pending;
  int    cycles     = 0;
  int    sent_total = 0;
  int    burst_left = 0;
  pace_t pace       = PACE_FREE;
  int    pace_left  = 0;
  logic  pace_bit;

  // Tuples and keys that made it into the table, for targeted lookups
  req_t stored_conns [$];

  connection_tuple_table_core dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  connection_table_checker checker_i (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .errors    (check_errors),
    .pending   (check_pending)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Abort a hung run
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  // Result side: switch between stall patterns
  always @(posedge clk) begin
    if (pace_left == 0) begin
      pace      = pace_t'($urandom_range(0, 3));
      pace_left = $urandom_range(8, 150);
    end else begin
      pace_left--;
    end
    case (pace)
      PACE_FREE:  pace_bit = 1'b0;
      PACE_LIGHT: pace_bit = ($urandom_range(0, 3) == 0);
      PACE_HEAVY: pace_bit = ($urandom_range(0, 9) < 7);
      default:    pace_bit = (pace_left % 3 == 0);
    endcase
    rsp_stall <= hold_rsp | pace_bit;
  end

  // Hold off results for a long stretch so the table backs up
  initial begin
    wait (sent_total >= HOLD_AFTER);
    @(posedge clk);
    hold_rsp <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_rsp <= 1'b0;
  end

  function automatic req_t conn_req(input logic [1:0] kind, input logic [15:0] key,
                                    input logic [31:0] sa, input logic [31:0] da,
                                    input logic [15:0] sp, input logic [15:0] dp);
    req_t r;
    r.kind     = kind;
    r.conn_key = key;
    r.src_addr = sa;
    r.dst_addr = da;
    r.src_port = sp;
    r.dst_port = dp;
    return r;
  endfunction

  // Mostly a small key pool so duplicates occur, sometimes any key
  function automatic logic [15:0] pick_key();
    int sel;
    sel = $urandom_range(0, 19);
    if (sel < 2) return 16'($urandom_range(0, 16'hFFFF));
    if (sel == 2) return 16'h0000;
    if (sel == 3) return 16'hFFFF;
    return 16'($urandom_range(0, KEY_POOL));
  endfunction

  // Random operation, biased toward records that exist
  function automatic req_t pick_op();
    req_t r;
    req_t t;
    int   sel;
    int   sub;
    int   b;
    r = conn_req(2'($urandom_range(0, 3)), pick_key(), $urandom, $urandom,
                 16'($urandom_range(0, 16'hFFFF)), 16'($urandom_range(0, 16'hFFFF)));
    sel = $urandom_range(0, 99);
    sub = $urandom_range(0, 99);
    if (stored_conns.size() > 0) begin
      t = stored_conns[$urandom_range(0, stored_conns.size() - 1)];
    end else begin
      t = r;
    end
    if (sel < 8) begin
      r.kind = KIND_INSERT;
      // duplicate tuple under a randomly picked key
      if (sub < 20) begin
        r.src_addr = t.src_addr;
        r.dst_addr = t.dst_addr;
        r.src_port = t.src_port;
        r.dst_port = t.dst_port;
      end
    end else if (sel < 56) begin
      r.kind = KIND_FIND;
      if (sub < 75) begin
        r.src_addr = t.src_addr;
        r.dst_addr = t.dst_addr;
        r.src_port = t.src_port;
        r.dst_port = t.dst_port;
      end
      // near miss: one bit off in one field
      if (sub >= 60 && sub < 75) begin
        b = $urandom_range(0, 31);
        case ($urandom_range(0, 3))
          0:       r.src_addr[b]      = ~r.src_addr[b];
          1:       r.dst_addr[b]      = ~r.dst_addr[b];
          2:       r.src_port[b % 16] = ~r.src_port[b % 16];
          default: r.dst_port[b % 16] = ~r.dst_port[b % 16];
        endcase
      end
    end else begin
      r.kind = (sel < 68) ? KIND_FINISH : KIND_READ;
      if (sub < 70) r.conn_key = t.conn_key;
    end
    return r;
  endfunction

  // Offer one transaction, in bursts separated by random gaps
  task automatic send_item(input req_t r);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
      if (gap > 0) begin
        req_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    req       <= r;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    burst_left--;
    sent_total++;
    if (r.kind == KIND_INSERT && stored_conns.size() < ENTRIES) stored_conns.push_back(r);
  endtask

  // Stop offering and wait for every owed result
  task automatic drain_results();
    req_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (check_pending != 0) @(posedge clk);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // empty table: every lookup misses
    send_item(conn_req(KIND_READ, 16'h1234, '0, '0, '0, '0));
    send_item(conn_req(KIND_FINISH, 16'h0000, '1, '1, '1, '1));
    send_item(conn_req(KIND_FIND, 16'h0000, '0, '0, '0, '0));
    // extremes, duplicate key, duplicate tuple
    send_item(conn_req(KIND_INSERT, 16'h0000, '0, '0, '0, '0));
    send_item(conn_req(KIND_INSERT, 16'hFFFF, '1, '1, '1, '1));
    send_item(conn_req(KIND_INSERT, 16'h0007, TUP_SRC, TUP_DST, TUP_SPORT, TUP_DPORT));
    send_item(conn_req(KIND_INSERT, 16'h0007, TUP_DST, TUP_SRC, TUP_DPORT, TUP_SPORT));
    send_item(conn_req(KIND_INSERT, 16'h0009, TUP_SRC, TUP_DST, TUP_SPORT, TUP_DPORT));
    send_item(conn_req(KIND_FIND, 16'hFFFF, '0, '0, '0, '0));
    send_item(conn_req(KIND_FIND, 16'h0000, '1, '1, '1, '1));
    send_item(conn_req(KIND_FIND, 16'h5A5A, TUP_SRC, TUP_DST, TUP_SPORT, TUP_DPORT));
    send_item(conn_req(KIND_FIND, 16'h0000, TUP_SRC, TUP_DST, TUP_SPORT, TUP_DPORT + 16'd1));
    send_item(conn_req(KIND_READ, 16'h0007, '1, '1, '1, '1));
    // finish the first of the duplicates, then look again
    send_item(conn_req(KIND_FINISH, 16'h0007, '0, '0, '0, '0));
    send_item(conn_req(KIND_FIND, 16'h0000, TUP_SRC, TUP_DST, TUP_SPORT, TUP_DPORT));
    send_item(conn_req(KIND_READ, 16'h0007, '0, '0, '0, '0));
    send_item(conn_req(KIND_FINISH, 16'h0007, '0, '0, '0, '0));
    send_item(conn_req(KIND_READ, 16'h5555, '0, '0, '0, '0));
    send_item(conn_req(KIND_FINISH, 16'hFFFF, '0, '0, '0, '0));
    send_item(conn_req(KIND_FIND, 16'h0000, '1, '1, '1, '1));
    send_item(conn_req(KIND_READ, 16'hFFFF, '0, '0, '0, '0));
    send_item(conn_req(KIND_READ, 16'h0000, '1, '1, '1, '1));
    drain_results();

    // random traffic, the table fills about halfway through
    for (int n = 0; n < RANDOM_OPS; n++) begin
      if (n == DRAIN_AT) drain_results();
      send_item(pick_op());
    end
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (check_errors == 0 && check_pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
